// ===== rtl/bba_pkg.sv =====
// Shared constants, types and codes for the bitmap block allocator.
// Used by bba_map_ram, bba_ctrl and bitmap_block_allocator; depends on nothing.
// BLOCK_BYTES must be a power of two so that address-to-block is a shift.
`timescale 1ns / 1ps

package bba_pkg;

   // Map geometry.
   localparam int NUM_BLOCKS  = 1024;
   localparam int BLOCK_BYTES = 4096;

   localparam int BLK_W   = $clog2(NUM_BLOCKS);
   localparam int CNT_W   = BLK_W + 1;
   localparam int LEN_W   = BLK_W + 1;
   localparam int SHIFT   = $clog2(BLOCK_BYTES);
   localparam int ADDR_W  = 32;
   localparam int REQ_W   = 22;
   localparam int NEED_W  = REQ_W + 1;

   localparam logic [BLK_W-1:0] LAST_BLK = BLK_W'(NUM_BLOCKS - 1);

   // Result codes.
   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_NO_SPACE     = 2'd1,
      STATUS_OUT_OF_RANGE = 2'd2,
      STATUS_NOT_ALLOC    = 2'd3
   } status_type;

   // Request opcodes.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_FREE_RD,
      ST_FREE_CHK,
      ST_FREE_CLR
   } state_type;

   // One map entry: used bit and the length of a run starting here.
   typedef struct packed {
      logic             used;
      logic [LEN_W-1:0] len;
   } map_word_type;

   // Memory access request from the sequencer.
   typedef struct packed {
      logic             we;
      logic [BLK_W-1:0] waddr;
      map_word_type     wdata;
      logic             re;
      logic [BLK_W-1:0] raddr;
   } mem_req_type;

   // Result beat.
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] address;
      status_type        status;
   } rsp_type;

endpackage

// ===== rtl/bba_map_ram.sv =====
// Block map memory: one write port, one read port, registered read data.
// Depends on bba_pkg for the depth and the entry type.
`timescale 1ns / 1ps

module bba_map_ram (
   input  logic                 clock,
   input  bba_pkg::mem_req_type mem_req,
   output bba_pkg::map_word_type rd_data
);

   bba_pkg::map_word_type mem_ff [bba_pkg::NUM_BLOCKS];
   bba_pkg::map_word_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // Read port with registered read data, held while no read is requested.
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rd_data_ff <= mem_ff[mem_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bba_ctrl.sv =====
// Sequencer of the allocator: clearing pass, first-fit scan, run marking
// and run release over the block map. Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_op,
   input  logic [bba_pkg::REQ_W-1:0]        req_request_bytes,
   input  logic [bba_pkg::ADDR_W-1:0]       req_free_address,
   input  logic [bba_pkg::ADDR_W-1:0]       region_base,
   output bba_pkg::mem_req_type             mem_req,
   input  bba_pkg::map_word_type            rd_data,
   output bba_pkg::rsp_type                 rsp
);

   bba_pkg::state_type           state_ff, state_in;
   logic [bba_pkg::CNT_W-1:0]    issue_ff, issue_in;
   logic [bba_pkg::BLK_W-1:0]    chk_ff, chk_in;
   logic                         chk_valid_ff, chk_valid_in;
   logic [bba_pkg::LEN_W-1:0]    count_ff, count_in;
   logic [bba_pkg::LEN_W-1:0]    need_ff, need_in;
   logic [bba_pkg::BLK_W-1:0]    start_blk_ff, start_blk_in;
   logic [bba_pkg::BLK_W-1:0]    cur_ff, cur_in;
   logic [bba_pkg::LEN_W-1:0]    left_ff, left_in;
   bba_pkg::rsp_type             rsp_ff, rsp_in;

   logic                         scan_re;
   logic [bba_pkg::NEED_W-1:0]   need_full;
   logic [bba_pkg::ADDR_W-1:0]   offset;
   logic [bba_pkg::ADDR_W-1:0]   blk_full;
   logic [bba_pkg::LEN_W-1:0]    count_inc;
   logic [bba_pkg::BLK_W-1:0]    found_start;

   // Request decoding and scan arithmetic.
   always_comb begin
      need_full   = (bba_pkg::NEED_W'(req_request_bytes) >> bba_pkg::SHIFT)
                    + bba_pkg::NEED_W'(1);
      offset      = req_free_address - region_base;
      blk_full    = offset >> bba_pkg::SHIFT;
      scan_re     = (issue_ff < bba_pkg::CNT_W'(bba_pkg::NUM_BLOCKS));
      count_inc   = count_ff + bba_pkg::LEN_W'(1);
      found_start = chk_ff - need_ff[bba_pkg::BLK_W-1:0] + bba_pkg::BLK_W'(1);
   end

   // Next state and register updates.
   always_comb begin
      state_in     = state_ff;
      issue_in     = issue_ff;
      chk_in       = chk_ff;
      chk_valid_in = 1'b0;
      count_in     = count_ff;
      need_in      = need_ff;
      start_blk_in = start_blk_ff;
      cur_in       = cur_ff;
      left_in      = left_ff;
      rsp_in       = rsp_ff;
      rsp_in.valid = 1'b0;

      case (state_ff)
         bba_pkg::ST_CLEAR: begin
            if (cur_ff == bba_pkg::LAST_BLK) begin
               state_in = bba_pkg::ST_IDLE;
            end else begin
               cur_in = cur_ff + bba_pkg::BLK_W'(1);
            end
         end
         bba_pkg::ST_IDLE: begin
            if (start) begin
               rsp_in.address = '0;
               if (req_op == bba_pkg::OP_ALLOC) begin
                  if (need_full > bba_pkg::NEED_W'(bba_pkg::NUM_BLOCKS - 1)) begin
                     rsp_in.valid  = 1'b1;
                     rsp_in.status = bba_pkg::STATUS_NO_SPACE;
                  end else begin
                     need_in  = need_full[bba_pkg::LEN_W-1:0];
                     count_in = '0;
                     issue_in = bba_pkg::CNT_W'(1);
                     state_in = bba_pkg::ST_SCAN;
                  end
               end else begin
                  if (blk_full >= bba_pkg::ADDR_W'(bba_pkg::NUM_BLOCKS)) begin
                     rsp_in.valid  = 1'b1;
                     rsp_in.status = bba_pkg::STATUS_OUT_OF_RANGE;
                  end else begin
                     start_blk_in = blk_full[bba_pkg::BLK_W-1:0];
                     state_in     = bba_pkg::ST_FREE_RD;
                  end
               end
            end
         end
         bba_pkg::ST_SCAN: begin
            // Reads are issued one block ahead of the check.
            if (scan_re) begin
               issue_in     = issue_ff + bba_pkg::CNT_W'(1);
               chk_in       = issue_ff[bba_pkg::BLK_W-1:0];
               chk_valid_in = 1'b1;
            end
            if (chk_valid_ff) begin
               if (!rd_data.used && (count_inc == need_ff)) begin
                  start_blk_in = found_start;
                  cur_in       = found_start;
                  left_in      = need_ff;
                  chk_valid_in = 1'b0;
                  state_in     = bba_pkg::ST_MARK;
               end else begin
                  count_in = rd_data.used ? '0 : count_inc;
                  if (chk_ff == bba_pkg::LAST_BLK) begin
                     rsp_in.valid   = 1'b1;
                     rsp_in.address = '0;
                     rsp_in.status  = bba_pkg::STATUS_NO_SPACE;
                     chk_valid_in   = 1'b0;
                     state_in       = bba_pkg::ST_IDLE;
                  end
               end
            end
         end
         bba_pkg::ST_MARK: begin
            if (left_ff == bba_pkg::LEN_W'(1)) begin
               rsp_in.valid   = 1'b1;
               rsp_in.address = region_base
                                + (bba_pkg::ADDR_W'(start_blk_ff) << bba_pkg::SHIFT);
               rsp_in.status  = bba_pkg::STATUS_OK;
               state_in       = bba_pkg::ST_IDLE;
            end else begin
               left_in = left_ff - bba_pkg::LEN_W'(1);
               cur_in  = cur_ff + bba_pkg::BLK_W'(1);
            end
         end
         bba_pkg::ST_FREE_RD: begin
            state_in = bba_pkg::ST_FREE_CHK;
         end
         bba_pkg::ST_FREE_CHK: begin
            if (rd_data.len == '0) begin
               rsp_in.valid   = 1'b1;
               rsp_in.address = '0;
               rsp_in.status  = bba_pkg::STATUS_NOT_ALLOC;
               state_in       = bba_pkg::ST_IDLE;
            end else begin
               left_in  = rd_data.len;
               cur_in   = start_blk_ff;
               state_in = bba_pkg::ST_FREE_CLR;
            end
         end
         bba_pkg::ST_FREE_CLR: begin
            // The run ends at its length or at the last block of the map.
            if ((left_ff == bba_pkg::LEN_W'(1)) || (cur_ff == bba_pkg::LAST_BLK)) begin
               rsp_in.valid   = 1'b1;
               rsp_in.address = '0;
               rsp_in.status  = bba_pkg::STATUS_OK;
               state_in       = bba_pkg::ST_IDLE;
            end else begin
               left_in = left_ff - bba_pkg::LEN_W'(1);
               cur_in  = cur_ff + bba_pkg::BLK_W'(1);
            end
         end
         default: begin
            state_in = bba_pkg::ST_IDLE;
         end
      endcase
   end

   // Memory requests and handshake outputs.
   always_comb begin
      mem_req       = '0;
      mem_req.waddr = cur_ff;
      mem_req.raddr = start_blk_ff;
      busy          = (state_ff != bba_pkg::ST_IDLE);
      case (state_ff)
         bba_pkg::ST_CLEAR: begin
            mem_req.we = 1'b1;
         end
         bba_pkg::ST_SCAN: begin
            mem_req.re    = scan_re;
            mem_req.raddr = issue_ff[bba_pkg::BLK_W-1:0];
         end
         bba_pkg::ST_MARK: begin
            // Only the first block of a run carries its length.
            mem_req.we         = 1'b1;
            mem_req.wdata.used = 1'b1;
            mem_req.wdata.len  = (cur_ff == start_blk_ff) ? need_ff : '0;
         end
         bba_pkg::ST_FREE_RD: begin
            mem_req.re = 1'b1;
         end
         bba_pkg::ST_FREE_CLR: begin
            mem_req.we = 1'b1;
         end
         default: begin
            mem_req.we = 1'b0;
         end
      endcase
   end

   assign rsp = rsp_ff;

   // Control registers and the result beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bba_pkg::ST_CLEAR;
         cur_ff       <= '0;
         chk_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         chk_valid_ff <= chk_valid_in;
         rsp_ff       <= rsp_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      issue_ff       <= issue_in;
      chk_ff         <= chk_in;
      count_ff       <= count_in;
      need_ff        <= need_in;
      start_blk_ff   <= start_blk_in;
      left_ff        <= left_in;
   end

endmodule

// ===== rtl/bitmap_block_allocator.sv =====
// First-fit bitmap block allocator. Allocate: the map is scanned from block 1 towards the last
// block, one map read per cycle, for a free run of the needed length, which is then marked; no
// fit after a full scan answers no space, and an oversize request answers from idle. Free: the
// run head is read, then one map write per block; no run or an out-of-range address is an error.
// The next request is taken in the cycle the result strobe is up; the receiver cannot stall.
// After reset a clearing pass zeroes the map with busy high.
`timescale 1ns / 1ps

module bitmap_block_allocator (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_op,
   input  logic [bba_pkg::REQ_W-1:0]  req_request_bytes,
   input  logic [bba_pkg::ADDR_W-1:0] req_free_address,
   output logic                       rsp_valid,
   output logic [bba_pkg::ADDR_W-1:0] rsp_block_address,
   output logic [1:0]                 rsp_status,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [bba_pkg::ADDR_W-1:0] csr_region_base
);

   logic [bba_pkg::ADDR_W-1:0] region_base_ff;
   bba_pkg::mem_req_type        mem_req;
   bba_pkg::map_word_type       rd_data;
   bba_pkg::rsp_type            rsp;

   // Region base register; always writable.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         region_base_ff <= csr_region_base;
      end
   end

   bba_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_request_bytes (req_request_bytes),
      .req_free_address  (req_free_address),
      .region_base       (region_base_ff),
      .mem_req           (mem_req),
      .rd_data           (rd_data),
      .rsp               (rsp)
   );

   bba_map_ram u_map_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign rsp_valid         = rsp.valid;
   assign rsp_block_address = rsp.address;
   assign rsp_status        = rsp.status;

   // An accepted request either starts work or answers in the next cycle.
   a_accept_progress : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither started nor answered");

   // A result beat only follows work or an accepted request.
   a_rsp_has_cause : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("result beat without a request");

   // Only a successful allocate returns a nonzero address.
   a_fail_zero_addr : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != bba_pkg::STATUS_OK)) |-> (rsp_block_address == '0))
      else $error("failed request returned an address");

   // The map is being cleared right after reset.
   a_clear_after_reset : assert property (@(posedge clock)
      $fell(reset) |-> busy)
      else $error("not busy during the clearing pass");

endmodule
